// ===== src/ubxrr_pkg.sv =====
// Shared types and constants for the rate-reply frame receiver.
// Depends on nothing; imported by ubxrr_parser and ubx_rate_reply_receiver.
`timescale 1ns / 1ps
`default_nettype none

package ubxrr_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CSUM_ERR = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] meas_rate;
        logic [15:0] nav_rate;
        logic [15:0] time_ref;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_step_res;

    // Frame layout: six header bytes, six payload bytes, two check bytes.
    localparam logic [3:0] HDR_LEN   = 4'd6;
    localparam logic [3:0] SUM_START = 4'd2;
    localparam logic [3:0] CK_A_POS  = 4'd12;
    localparam logic [3:0] LAST_POS  = 4'd13;

    localparam logic [7:0]  SYNC_1        = 8'hB5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = SYNC_1;
            3'd1:    b = 8'h62;
            3'd2:    b = 8'h06;
            3'd3:    b = 8'h08;
            3'd4:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== src/ubxrr_parser.sv =====
// Frame state of the receiver: header match, Fletcher-8 sums, payload capture
// and tick counting, one word per enabled cycle. Depends on ubxrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubxrr_parser
    import ubxrr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire t_in_word    i_word,
    input  wire logic [15:0] i_timeout,
    output t_step_res        o_res
);

    logic        r_armed, n_armed;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [15:0] r_ticks, n_ticks;
    logic [7:0]  r_payload [6];
    logic [7:0]  n_payload [6];
    logic [7:0]  r_ck_a, n_ck_a;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] ticks_inc;
    logic [3:0]  pay_off;

    assign add_a     = r_sum_a + i_word.rx_byte;
    assign add_b     = r_sum_b + add_a;
    assign ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign pay_off   = r_pos - HDR_LEN;

    always_comb begin
        n_armed   = r_armed;
        n_pos     = r_pos;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_ticks   = r_ticks;
        n_payload = r_payload;
        n_ck_a    = r_ck_a;
        o_res     = '0;

        unique case (i_word.opcode)
            OP_START: begin
                n_armed = 1'b1;
                n_pos   = '0;
                n_sum_a = '0;
                n_sum_b = '0;
                n_ticks = '0;
            end
            OP_TICK: begin
                if (r_armed) begin
                    n_ticks = ticks_inc;
                    if (ticks_inc >= i_timeout) begin
                        n_armed            = 1'b0;
                        o_res.valid        = 1'b1;
                        o_res.word.status  = ST_TIMEOUT;
                    end
                end
            end
            OP_BYTE: begin
                if (r_armed) begin
                    if (r_pos < HDR_LEN) begin
                        if (i_word.rx_byte == hdr_byte(r_pos[2:0])) begin
                            if (r_pos >= SUM_START) begin
                                n_sum_a = add_a;
                                n_sum_b = add_b;
                            end
                            n_pos = r_pos + 4'd1;
                        end else begin
                            // Resync; a stray first sync byte may open a new frame.
                            n_pos   = (i_word.rx_byte == SYNC_1) ? 4'd1 : 4'd0;
                            n_sum_a = '0;
                            n_sum_b = '0;
                        end
                    end else if (r_pos < CK_A_POS) begin
                        n_payload[pay_off[2:0]] = i_word.rx_byte;
                        n_sum_a = add_a;
                        n_sum_b = add_b;
                        n_pos   = r_pos + 4'd1;
                    end else if (r_pos == CK_A_POS) begin
                        n_ck_a = i_word.rx_byte;
                        n_pos  = r_pos + 4'd1;
                    end else begin
                        n_armed     = 1'b0;
                        n_pos       = '0;
                        o_res.valid = 1'b1;
                        if (r_ck_a != r_sum_a || i_word.rx_byte != r_sum_b) begin
                            o_res.word.status = ST_CSUM_ERR;
                        end else begin
                            o_res.word.status    = ST_OK;
                            o_res.word.meas_rate = {r_payload[1], r_payload[0]};
                            o_res.word.nav_rate  = {r_payload[3], r_payload[2]};
                            o_res.word.time_ref  = {r_payload[5], r_payload[4]};
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_pos   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_ticks <= '0;
        end else if (i_step) begin
            r_armed <= n_armed;
            r_pos   <= n_pos;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_ticks <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_payload <= n_payload;
            r_ck_a    <= n_ck_a;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("frame position beyond last check byte");

    a_result_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.valid |=> !r_armed)
        else $error("receiver still armed after giving a result");

    a_result_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> r_armed)
        else $error("result produced while idle");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_word.opcode == OP_START |=> r_armed && r_pos == 4'd0
            && r_ticks == 16'd0)
        else $error("start did not rearm the receiver");
`endif

endmodule

`default_nettype wire

// ===== src/ubx_rate_reply_receiver.sv =====
// A word accepted into the input register is processed when it moves on into the frame logic;
// any result it gives is loaded into the result register, which drives o_out_valid.
// Throughput: one word per cycle, set by the single input register feeding the
// frame logic; processing stalls only while a result waits and i_out_ready is low.
// Reset (synchronous, active low) idles the receiver and loads timeout 200.
// Top level of the rate-reply frame receiver; depends on ubxrr_pkg and ubxrr_parser.
`timescale 1ns / 1ps
`default_nettype none

module ubx_rate_reply_receiver
    import ubxrr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_word        o_out_word,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    logic        r_in_valid, n_in_valid;
    t_in_word    r_in_word;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word;
    logic [15:0] r_timeout;

    logic        advance;
    logic        in_accept;
    t_step_res   step_res;

    // The held word moves on whenever the result register can take a result.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    ubxrr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_word    (r_in_word),
        .i_timeout (r_timeout),
        .o_res     (step_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance && step_res.valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
        if (advance && step_res.valid) begin
            r_out_word <= step_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_word))
        else $error("held input word lost or changed while stalled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !(advance && step_res.valid))
        else $error("result register overwritten before it was taken");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_word))
        else $error("waiting result dropped or changed");
`endif

endmodule

`default_nettype wire
